>>> rtl/lsbse_pkg.sv
// lsbse_pkg: types and constants for the lsb stego extractor
// no dependencies
`default_nettype none

package lsbse_pkg;

   typedef enum logic [1:0] {
      MODE_LSB1 = 2'd0,
      MODE_LSB4 = 2'd1,
      MODE_LSBI = 2'd2
   } mode_type;

   localparam logic [7:0] PATTERN_MASK = 8'h06;
   localparam logic [3:0] NIBBLE_MASK  = 4'hF;
   localparam logic [2:0] HEADER_LEN   = 3'd4;
   localparam logic [3:0] NEED_BITS    = 4'd8;
   localparam logic [3:0] NEED_NIBBLES = 4'd2;
   localparam logic [1:0] LAST_POS     = 2'd2;

endpackage

`default_nettype wire

>>> rtl/lsb_stego_extractor.sv
// lsb_stego_extractor: rebuilds hidden bytes from carrier bytes (lsb1, lsb4, lsbi)
// depends on lsbse_pkg
//
//   channel   direction   ports                                   moves
//   req       in          req_valid/ready, carrier_byte, first    one carrier byte per item
//   rsp       out         rsp_valid/ready, rsp_hidden_byte        one hidden byte per item
//   csr       in          csr_valid/ready, csr_mode               extraction mode write
//
// one carrier item is taken per cycle; its result, if any, shows in the
// output register the next cycle. req_ready is low only while a result
// waits and rsp_ready is low: the single output register sets the rate.
// synchronous reset clears mode to lsb1 and all stream state.
// csr_ready is always high.
`default_nettype none

module lsb_stego_extractor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_carrier_byte,
   input  wire logic       req_first_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_hidden_byte,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_mode
);

   lsbse_pkg::mode_type mode_ff, mode_in;
   logic [1:0] pos_ff, pos_in;
   logic [2:0] hdr_ff, hdr_in;
   logic [3:0] flags_ff, flags_in;
   logic [7:0] acc_ff, acc_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [1:0] pos_cur;
   logic [2:0] hdr_cur;
   logic [3:0] flags_cur;
   logic [7:0] acc_cur;
   logic [2:0] cnt_cur;
   logic       push;
   logic [7:0] acc_shift;
   logic [3:0] need;
   logic [3:0] cnt_next;
   logic [1:0] pat;
   logic       lsbi_bit;
   logic       emit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hidden_byte = rsp_data_ff;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         mode_in = lsbse_pkg::mode_type'(csr_mode);
      end
   end

   always_comb begin
      // a new carrier clears the stream before this item is used
      pos_cur   = req_first_byte ? 2'd0 : pos_ff;
      hdr_cur   = req_first_byte ? 3'd0 : hdr_ff;
      flags_cur = req_first_byte ? 4'd0 : flags_ff;
      acc_cur   = req_first_byte ? 8'd0 : acc_ff;
      cnt_cur   = req_first_byte ? 3'd0 : cnt_ff;

      pos_in   = (pos_cur == lsbse_pkg::LAST_POS) ? 2'd0 : pos_cur + 2'd1;
      hdr_in   = hdr_cur;
      flags_in = flags_cur;
      acc_in   = acc_cur;
      cnt_in   = cnt_cur;

      pat      = 2'((req_carrier_byte & lsbse_pkg::PATTERN_MASK) >> 1);
      lsbi_bit = req_carrier_byte[0] ^ flags_cur[pat];

      push      = 1'b0;
      acc_shift = {acc_cur[6:0], req_carrier_byte[0]};
      need      = lsbse_pkg::NEED_BITS;

      case (mode_ff)
         lsbse_pkg::MODE_LSB1: begin
            push = 1'b1;
         end
         lsbse_pkg::MODE_LSB4: begin
            push      = 1'b1;
            acc_shift = {acc_cur[3:0], req_carrier_byte[3:0] & lsbse_pkg::NIBBLE_MASK};
            need      = lsbse_pkg::NEED_NIBBLES;
         end
         lsbse_pkg::MODE_LSBI: begin
            if (hdr_cur < lsbse_pkg::HEADER_LEN) begin
               flags_in = flags_cur | (4'(req_carrier_byte[0]) << hdr_cur[1:0]);
               hdr_in   = hdr_cur + 3'd1;
            end else if (pos_cur != lsbse_pkg::LAST_POS) begin
               push      = 1'b1;
               acc_shift = {acc_cur[6:0], lsbi_bit};
            end
         end
         default: begin
         end
      endcase

      cnt_next = {1'b0, cnt_cur} + 4'd1;
      emit     = push && (cnt_next >= need);
      if (push) begin
         if (emit) begin
            acc_in = 8'd0;
            cnt_in = 3'd0;
         end else begin
            acc_in = acc_shift;
            cnt_in = cnt_next[2:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = emit;
         rsp_data_in  = acc_shift;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lsbse_pkg::MODE_LSB1;
         pos_ff       <= 2'd0;
         hdr_ff       <= 3'd0;
         flags_ff     <= 4'd0;
         acc_ff       <= 8'd0;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pos_ff   <= pos_in;
            hdr_ff   <= hdr_in;
            flags_ff <= flags_in;
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> tb/sv/lsb_stego_extractor_tb.sv
// lsb_stego_extractor_tb: self-checking testbench for the lsb stego extractor
// drives carrier items through all three modes, predicts hidden bytes and checks them
// depends on lsbse_pkg and lsb_stego_extractor
`timescale 1ns / 100ps

module lsb_stego_extractor_tb;

   localparam int HALF_PERIOD  = 5;
   localparam int DRAIN_CYCLES = 4;
   localparam int GAP_PCT      = 13;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int NUM_PHASES   = 7;

   typedef struct packed {
      logic [7:0] carrier;
      logic       first;
   } carrier_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_carrier_byte = 8'h00;
   logic       req_first_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_hidden_byte;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_mode = 2'd0;

   lsb_stego_extractor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_carrier_byte (req_carrier_byte),
      .req_first_byte   (req_first_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hidden_byte  (rsp_hidden_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_mode         (csr_mode)
   );

   always #HALF_PERIOD clock = ~clock;

   carrier_item_type pending_carriers[$];
   logic [7:0]       expected_hidden[$];

   // shadow of the extractor state
   lsbse_pkg::mode_type mode_q = lsbse_pkg::MODE_LSB1;
   logic [1:0] pos_mod3  = 2'd0;
   logic [2:0] hdr_count = 3'd0;
   logic [3:0] inv_flags = 4'd0;
   logic [7:0] hidden_acc = 8'd0;
   logic [2:0] piece_cnt = 3'd0;

   int unsigned items_accepted = 0;
   int unsigned bytes_seen = 0;
   int unsigned fail_count = 0;
   int unsigned hold_left = 0;
   logic        long_hold_done = 1'b0;
   int unsigned stream_left = 0;
   logic [7:0]  hidden_front;

   function automatic void shift_in_piece(logic [3:0] piece, logic nibble, logic [3:0] need);
      logic [3:0] n;
      n = {1'b0, piece_cnt} + 4'd1;
      hidden_acc = nibble ? {hidden_acc[3:0], piece} : {hidden_acc[6:0], piece[0]};
      if (n >= need) begin
         expected_hidden.push_back(hidden_acc);
         hidden_acc = 8'd0;
         piece_cnt = 3'd0;
      end else begin
         piece_cnt = n[2:0];
      end
   endfunction

   function automatic void extract_step(logic [7:0] c, logic first);
      logic [1:0] pos;
      logic [1:0] pat;
      if (first) begin
         pos_mod3 = 2'd0;
         hdr_count = 3'd0;
         inv_flags = 4'd0;
         hidden_acc = 8'd0;
         piece_cnt = 3'd0;
      end
      pos = pos_mod3;
      pos_mod3 = (pos >= lsbse_pkg::LAST_POS) ? 2'd0 : pos + 2'd1;
      case (mode_q)
         lsbse_pkg::MODE_LSB1: begin
            shift_in_piece({3'b000, c[0]}, 1'b0, lsbse_pkg::NEED_BITS);
         end
         lsbse_pkg::MODE_LSB4: begin
            shift_in_piece(c[3:0] & lsbse_pkg::NIBBLE_MASK, 1'b1, lsbse_pkg::NEED_NIBBLES);
         end
         lsbse_pkg::MODE_LSBI: begin
            if (hdr_count < lsbse_pkg::HEADER_LEN) begin
               inv_flags = inv_flags | (4'(c[0]) << hdr_count);
               hdr_count = hdr_count + 3'd1;
            end else if (pos != lsbse_pkg::LAST_POS) begin
               pat = 2'((c & lsbse_pkg::PATTERN_MASK) >> 1);
               shift_in_piece({3'b000, c[0] ^ inv_flags[pat]}, 1'b0, lsbse_pkg::NEED_BITS);
            end
         end
         default: ;
      endcase
   endfunction

   // no gaps at all in the middle of the run
   function automatic logic take_gap();
      return !(items_accepted >= 450 && items_accepted < 600) &&
             ($urandom_range(99) < GAP_PCT);
   endfunction

   // carrier driver
   always @(posedge clock) begin
      carrier_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            extract_step(req_carrier_byte, req_first_byte);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_carriers.size() != 0 && !take_gap()) begin
               next_item = pending_carriers.pop_front();
               req_valid <= 1'b1;
               req_carrier_byte <= next_item.carrier;
               req_first_byte <= next_item.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // hidden byte monitor and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_seen++;
         if (expected_hidden.size() == 0) begin
            $error("hidden_byte: expected none, actual %02h", rsp_hidden_byte);
            fail_count++;
         end else begin
            hidden_front = expected_hidden.pop_front();
            if (rsp_hidden_byte !== hidden_front) begin
               $error("hidden_byte: expected %02h, actual %02h", hidden_front, rsp_hidden_byte);
               fail_count++;
            end
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && bytes_seen >= 40 && pending_carriers.size() > 30) begin
         // long hold so the output register fills and the input stalls
         long_hold_done = 1'b1;
         hold_left = 120;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_gap();
      end
   end

   task automatic push_carrier(logic [7:0] c, logic first);
      pending_carriers.push_back('{carrier: c, first: first});
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_carriers.size() != 0 || req_valid || expected_hidden.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(lsbse_pkg::mode_type m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_q = m;
      @(negedge clock);
   endtask

   // random carrier items, mostly well-formed streams with a few stray restarts
   task automatic push_random(int unsigned n);
      logic first;
      repeat (n) begin
         first = 1'b0;
         if (stream_left == 0) begin
            first = 1'b1;
            stream_left = $urandom_range(90, 4);
         end else if ($urandom_range(99) < 3) begin
            first = 1'b1;
         end
         stream_left--;
         push_carrier(8'($urandom), first);
      end
   endtask

   initial begin
      lsbse_pkg::mode_type plan_mode [NUM_PHASES];
      int unsigned         plan_items [NUM_PHASES];

      plan_mode  = '{lsbse_pkg::MODE_LSB4, lsbse_pkg::MODE_LSBI, lsbse_pkg::MODE_LSB1,
                     lsbse_pkg::MODE_LSBI, lsbse_pkg::MODE_LSB4, lsbse_pkg::MODE_LSB1,
                     lsbse_pkg::MODE_LSBI};
      plan_items = '{140, 150, 140, 130, 120, 110, 135};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lsb1: extremes, one full byte, then a partial byte left behind
      write_mode(lsbse_pkg::MODE_LSB1);
      push_carrier(8'hFF, 1'b1);
      push_carrier(8'h00, 1'b0);
      push_carrier(8'h01, 1'b0);
      push_carrier(8'hFE, 1'b0);
      push_carrier(8'h80, 1'b0);
      push_carrier(8'h7F, 1'b0);
      push_carrier(8'hAA, 1'b0);
      push_carrier(8'h55, 1'b0);
      push_carrier(8'hFF, 1'b0);
      push_carrier(8'h01, 1'b0);
      push_carrier(8'h00, 1'b0);
      wait_drained();

      // lsb4 picks up the partial byte without clearing, then a restart drops a half-built byte
      write_mode(lsbse_pkg::MODE_LSB4);
      push_carrier(8'h0F, 1'b0);
      push_carrier(8'hF0, 1'b0);
      push_carrier(8'hA5, 1'b1);
      push_carrier(8'h3C, 1'b0);
      wait_drained();

      // lsbi: header flags, then all four patterns across skipped positions
      write_mode(lsbse_pkg::MODE_LSBI);
      push_carrier(8'h01, 1'b1);
      push_carrier(8'h00, 1'b0);
      push_carrier(8'h01, 1'b0);
      push_carrier(8'h01, 1'b0);
      push_carrier(8'h00, 1'b0);
      push_carrier(8'h02, 1'b0);
      push_carrier(8'h04, 1'b0);
      push_carrier(8'h06, 1'b0);
      push_carrier(8'h07, 1'b0);
      push_carrier(8'h03, 1'b0);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_mode(plan_mode[p]);
         if (p == 1) begin
            // sender pauses until every hidden byte is back
            push_random(plan_items[p] / 2);
            wait_drained();
            push_random(plan_items[p] - plan_items[p] / 2);
         end else begin
            push_random(plan_items[p]);
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
